// File: src/shared_buffer_multi_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// shared buffer multi queue unit assertion macros
// concurrent assertion wrappers shared by the checker files
// ----------------------------------------------------------------------------
`ifndef SHARED_BUFFER_MULTI_QUEUE_UNIT_MACROS_SVH
`define SHARED_BUFFER_MULTI_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define SBMQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sbmq assertion failed");

// next-cycle implication
`define SBMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sbmq assertion failed");

`endif

// File: src/sbmq_pkg.sv
// ----------------------------------------------------------------------------
// sbmq_pkg
// beat types, command and status codes, controller/datapath interface
// ----------------------------------------------------------------------------
package sbmq_pkg;

    localparam logic [1:0] CMD_ENQ   = 2'd0;
    localparam logic [1:0] CMD_DEQ   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [1:0]         queue_id;
        logic signed [31:0] data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic               is_empty;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic exec;
        logic link;
        logic fetch;
        logic report;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic go_link;
        logic is_deq;
    } t_stat;

endpackage

// File: src/sbmq_ram.sv
// ----------------------------------------------------------------------------
// sbmq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sbmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/sbmq_ctrl.sv
// ----------------------------------------------------------------------------
// sbmq_ctrl
// command sequencer: link clearing pass, then one command at a time
// ----------------------------------------------------------------------------
module sbmq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  sbmq_pkg::t_stat i_stat,
    output sbmq_pkg::t_ctrl o_ctrl,
    output logic            busy
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_EXEC   = 6'b000100,
        S_LINK   = 6'b001000,
        S_FETCH  = 6'b010000,
        S_REPORT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   open;

    // idle and report both take a new command
    assign open = (r_state == S_IDLE) || (r_state == S_REPORT);
    assign busy = !open;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_stat.go_link ? S_LINK : S_REPORT;
            end
            S_LINK: begin
                n_state = i_stat.is_deq ? S_FETCH : S_REPORT;
            end
            S_FETCH: begin
                n_state = S_REPORT;
            end
            S_REPORT: begin
                n_state = start ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_ctrl.clr_step = (r_state == S_CLEAR);
        o_ctrl.load     = open && start;
        o_ctrl.exec     = (r_state == S_EXEC);
        o_ctrl.link     = (r_state == S_LINK);
        o_ctrl.fetch    = (r_state == S_FETCH);
        o_ctrl.report   = (r_state == S_REPORT);
    end

endmodule

// File: src/sbmq_datapath.sv
// ----------------------------------------------------------------------------
// sbmq_datapath
// link and data stores, queue head/tail registers, free list head, result
// ----------------------------------------------------------------------------
module sbmq_datapath #(
    parameter int SLOTS  = 16,
    parameter int QUEUES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sbmq_pkg::t_ctrl     i_ctrl,
    input  sbmq_pkg::t_in_item  i_item,
    output sbmq_pkg::t_stat     o_stat,
    output logic                o_valid,
    output sbmq_pkg::t_out_item o_result
);

    localparam int AW = $clog2(SLOTS);
    localparam int IW = $clog2(SLOTS + 1);
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam logic [IW-1:0] NIL = IW'(SLOTS);

    sbmq_pkg::t_in_item  r_cmd;
    logic                r_qok;
    logic [1:0]          r_status;
    logic [IW-1:0]       r_head [QUEUES];
    logic [IW-1:0]       r_tail [QUEUES];
    logic signed [31:0]  r_front [QUEUES];
    logic signed [31:0]  r_back [QUEUES];
    logic [IW-1:0]       r_free;
    logic [AW-1:0]       r_clr;
    logic                r_valid;
    sbmq_pkg::t_out_item r_result;

    logic [QW-1:0] qi;
    logic [IW-1:0] cur_h;
    logic [IW-1:0] cur_t;
    logic          q_empty;
    logic          free_ok;
    logic          is_enq;
    logic          is_deq;
    logic          enq_ok;
    logic          deq_one;
    logic          deq_multi;

    logic          lk_we;
    logic [AW-1:0] lk_waddr;
    logic [IW-1:0] lk_wdata;
    logic [AW-1:0] lk_raddr;
    logic [IW-1:0] lk_rdata;
    logic          dt_we;
    logic [31:0]   dt_rdata;

    assign qi      = QW'(r_cmd.queue_id);
    assign cur_h   = r_head[qi];
    assign cur_t   = r_tail[qi];
    assign q_empty = !((cur_h < NIL) && (cur_t < NIL));
    assign free_ok = (r_free < NIL);
    assign is_enq  = (r_cmd.command == sbmq_pkg::CMD_ENQ);
    assign is_deq  = (r_cmd.command == sbmq_pkg::CMD_DEQ);

    assign enq_ok    = r_qok && is_enq && free_ok;
    assign deq_one   = r_qok && is_deq && !q_empty && (cur_h == cur_t);
    assign deq_multi = r_qok && is_deq && !q_empty && (cur_h != cur_t);

    assign o_stat.clr_done = (r_clr == AW'(SLOTS - 1));
    assign o_stat.go_link  = enq_ok || deq_multi;
    assign o_stat.is_deq   = is_deq;

    // link store port steering
    always_comb begin
        lk_we    = 1'b0;
        lk_waddr = cur_t[AW-1:0];
        lk_wdata = r_free;
        lk_raddr = r_free[AW-1:0];
        dt_we    = 1'b0;
        if (i_ctrl.clr_step) begin
            lk_we    = 1'b1;
            lk_waddr = r_clr;
            lk_wdata = IW'(r_clr) + IW'(1);
        end else if (i_ctrl.exec) begin
            if (enq_ok) begin
                dt_we = 1'b1;
                // append after the old tail
                lk_we = !q_empty;
            end else if (deq_one) begin
                lk_we    = 1'b1;
                lk_waddr = cur_h[AW-1:0];
            end else if (deq_multi) begin
                lk_raddr = cur_h[AW-1:0];
            end
        end else if (i_ctrl.link) begin
            lk_we = 1'b1;
            if (is_deq) begin
                lk_waddr = cur_h[AW-1:0];
            end else begin
                lk_waddr = r_free[AW-1:0];
                lk_wdata = NIL;
            end
        end
    end

    sbmq_ram #(
        .WIDTH (IW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    sbmq_ram #(
        .WIDTH (32),
        .DEPTH (SLOTS)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (dt_we),
        .i_waddr (r_free[AW-1:0]),
        .i_wdata (r_cmd.data),
        .i_raddr (lk_rdata[AW-1:0]),
        .o_rdata (dt_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUES; i++) begin
                r_head[i] <= NIL;
                r_tail[i] <= NIL;
            end
            r_free  <= '0;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctrl.report;
            if (i_ctrl.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_ctrl.exec && deq_one) begin
                r_free     <= cur_h;
                r_head[qi] <= NIL;
                r_tail[qi] <= NIL;
            end
            if (i_ctrl.link) begin
                if (is_deq) begin
                    r_free <= cur_h;
                    if (lk_rdata < NIL) begin
                        r_head[qi] <= lk_rdata;
                    end else begin
                        r_head[qi] <= NIL;
                        r_tail[qi] <= NIL;
                    end
                end else begin
                    r_free     <= lk_rdata;
                    r_tail[qi] <= r_free;
                    if (q_empty) begin
                        r_head[qi] <= r_free;
                    end
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= i_item;
            r_qok <= ({30'd0, i_item.queue_id} < 32'(QUEUES));
        end
        if (i_ctrl.exec) begin
            if (r_qok && is_enq && !free_ok) begin
                r_status <= sbmq_pkg::ST_FULL;
            end else if (r_qok && is_deq && q_empty) begin
                r_status <= sbmq_pkg::ST_EMPTY;
            end else begin
                r_status <= sbmq_pkg::ST_DONE;
            end
        end
        if (i_ctrl.link && !is_deq) begin
            r_back[qi] <= r_cmd.data;
            if (q_empty) begin
                r_front[qi] <= r_cmd.data;
            end
        end
        if (i_ctrl.fetch) begin
            r_front[qi] <= dt_rdata;
        end
        if (i_ctrl.report) begin
            if (!r_qok) begin
                r_result.status      <= sbmq_pkg::ST_DONE;
                r_result.is_empty    <= 1'b1;
                r_result.front_value <= '0;
                r_result.back_value  <= '0;
            end else begin
                r_result.status      <= r_status;
                r_result.is_empty    <= q_empty;
                r_result.front_value <= q_empty ? 32'sd0 : r_front[qi];
                r_result.back_value  <= q_empty ? 32'sd0 : r_back[qi];
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: src/shared_buffer_multi_queue_unit.sv
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_unit
// several fifo queues over one slot store, chained by a link store, with
// unused slots kept on a free list
// ----------------------------------------------------------------------------
//
//   channel   handshake          payload
//   --------  -----------------  ---------------------------------------
//   command   start / busy       i_item  (command, queue_id, data)
//   result    o_valid strobe     o_result (status, is_empty, front, back)
//
// after reset the link store is initialized one slot a cycle with busy
// high. a beat is taken when start is high and busy is low. a query, a
// refused command or a dequeue of the last entry passes exec and report;
// an enqueue adds a link update, and other dequeues add a link update
// and a data fetch, as the link store and the data store have single read
// ports. o_valid marks each result for one cycle; it cannot be held off.
//
module shared_buffer_multi_queue_unit #(
    parameter int SLOTS  = 16,  // slots in the shared store, 2 to 4096
    parameter int QUEUES = 4    // queues, 1 to 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sbmq_pkg::t_in_item  i_item,
    output logic                o_valid,
    output sbmq_pkg::t_out_item o_result
);

    // command and status between sequencer and datapath
    sbmq_pkg::t_ctrl ctrl;
    sbmq_pkg::t_stat stat;

    // sequencer: clearing pass, exec, link update, data fetch, report
    sbmq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .busy    (busy)
    );

    // stores, per-queue head/tail and cached front/back words
    sbmq_datapath #(
        .SLOTS  (SLOTS),
        .QUEUES (QUEUES)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_item   (i_item),
        .o_stat   (stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

// File: src/sbmq_checker.sv
// ----------------------------------------------------------------------------
// sbmq_checker
// port-level checks on the queue unit, bound to the top level
// ----------------------------------------------------------------------------
`include "shared_buffer_multi_queue_unit_macros.svh"

module sbmq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_valid,
    input sbmq_pkg::t_out_item o_result
);

    logic accept;

    assign accept = start && !busy;

    // a taken command keeps the unit busy for its exec cycle
    `SBMQ_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy)

    // result beats never come back to back
    `SBMQ_ASSERT_NEXT(a_valid_single, i_clk, i_rst_n, o_valid, !o_valid)

    // refused dequeue leaves the queue empty
    `SBMQ_ASSERT_SAME(a_empty_status, i_clk, i_rst_n,
        o_valid && (o_result.status == sbmq_pkg::ST_EMPTY), o_result.is_empty)

    // empty queue reports zero words
    `SBMQ_ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, o_valid && o_result.is_empty,
        (o_result.front_value == 32'sd0) && (o_result.back_value == 32'sd0))

endmodule

bind shared_buffer_multi_queue_unit sbmq_checker u_sbmq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

// File: tb/sv/sbmq_queue_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmq_queue_check
// watches the command and result channels, keeps its own copy of the queues,
// the link store and the free list, and compares every result beat with the
// oldest predicted result
// ----------------------------------------------------------------------------
module sbmq_queue_check
    import sbmq_pkg::*;
#(
    parameter int SLOTS  = 16,
    parameter int QUEUES = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_busy,
    input  t_in_item  i_item,
    input  logic      i_valid,
    input  t_out_item i_result,
    output int        o_errors,
    output int        o_pending
);

    localparam int            PW        = $clog2(SLOTS + 1);
    localparam logic [PW-1:0] NO_SLOT   = PW'(SLOTS);
    localparam int            PRINT_CAP = 200;

    logic [31:0]   slot_word [SLOTS];
    logic [PW-1:0] slot_next [SLOTS];
    logic [PW-1:0] q_head    [QUEUES];
    logic [PW-1:0] q_tail    [QUEUES];
    logic [PW-1:0] free_first;

    t_out_item predicted_results[$];
    int        mismatches = 0;

    function automatic bit is_slot(logic [PW-1:0] s);
        return s < SLOTS;
    endfunction

    task automatic clear_queues();
        for (int i = 0; i < SLOTS; i++) begin
            slot_word[i] = '0;
            slot_next[i] = (i + 1 < SLOTS) ? PW'(i + 1) : NO_SLOT;
        end
        for (int i = 0; i < QUEUES; i++) begin
            q_head[i] = NO_SLOT;
            q_tail[i] = NO_SLOT;
        end
        free_first = '0;
    endtask

    // applies one command to the shadow state and returns the result it gives
    function automatic t_out_item apply_command(t_in_item cmd_beat);
        t_out_item     res;
        logic [PW-1:0] h;
        logic [PW-1:0] t;
        logic [PW-1:0] s;
        logic [PW-1:0] nxt;
        int            q;
        res = '0;
        q   = cmd_beat.queue_id;
        if (q >= QUEUES) begin
            res.is_empty = 1'b1;
            return res;
        end
        h = q_head[q];
        t = q_tail[q];
        case (cmd_beat.command)
            CMD_ENQ: begin
                s = free_first;
                if (!is_slot(s)) begin
                    res.status = ST_FULL;
                end else begin
                    slot_word[s] = cmd_beat.data;
                    free_first   = slot_next[s];
                    slot_next[s] = NO_SLOT;
                    if (!is_slot(h) || !is_slot(t)) begin
                        q_head[q] = s;
                    end else begin
                        slot_next[t] = s;
                    end
                    q_tail[q] = s;
                end
            end
            CMD_DEQ: begin
                if (!is_slot(h) || !is_slot(t)) begin
                    res.status = ST_EMPTY;
                end else if (h == t) begin
                    slot_next[h] = free_first;
                    free_first   = h;
                    q_head[q]    = NO_SLOT;
                    q_tail[q]    = NO_SLOT;
                end else begin
                    nxt          = slot_next[h];
                    q_head[q]    = is_slot(nxt) ? nxt : NO_SLOT;
                    if (!is_slot(nxt)) q_tail[q] = NO_SLOT;
                    slot_next[h] = free_first;
                    free_first   = h;
                end
            end
            default: ;  // query, and the spare code behaves as a query
        endcase
        h = q_head[q];
        t = q_tail[q];
        if (is_slot(h) && is_slot(t)) begin
            res.is_empty    = 1'b0;
            res.front_value = slot_word[h];
            res.back_value  = slot_word[t];
        end else begin
            res.is_empty = 1'b1;
        end
        return res;
    endfunction

    task automatic report(string what);
        mismatches++;
        if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            clear_queues();
            predicted_results.delete();
        end else begin
            if (i_start && !i_busy) predicted_results.push_back(apply_command(i_item));
            if (i_valid) begin
                if (predicted_results.size() == 0) begin
                    report("result beat with no command waiting");
                end else begin
                    want = predicted_results.pop_front();
                    if (i_result.status !== want.status)
                        report($sformatf("status got %0d want %0d",
                                         i_result.status, want.status));
                    if (i_result.is_empty !== want.is_empty)
                        report($sformatf("is_empty got %0b want %0b",
                                         i_result.is_empty, want.is_empty));
                    if (i_result.front_value !== want.front_value)
                        report($sformatf("front_value got %0d want %0d",
                                         i_result.front_value, want.front_value));
                    if (i_result.back_value !== want.back_value)
                        report($sformatf("back_value got %0d want %0d",
                                         i_result.back_value, want.back_value));
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= predicted_results.size();
    end

endmodule

// File: tb/sv/tb_shared_buffer_multi_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shared_buffer_multi_queue_unit
// drives command beats into the shared buffer queue unit, directed first and
// then random with idle gaps; the queue check beside the block predicts and
// compares each result beat, and this top gives the verdict
// ----------------------------------------------------------------------------
module tb_shared_buffer_multi_queue_unit;
    import sbmq_pkg::*;

    localparam int SLOTS        = 16;
    localparam int QUEUES       = 4;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_BEATS = 400;
    localparam int DRAIN_CYCLES = 8;
    // far beyond the length of the slowest run
    localparam int CYCLE_LIMIT  = 100000;

    // unused command code, which the block answers as a query
    localparam logic [1:0] CMD_SPARE = 2'd3;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  item    = '0;
    logic      busy;
    logic      o_valid;
    t_out_item o_result;

    int errors;
    int pending;
    int cycles = 0;
    bit calm   = 1'b0;   // set during the stretch with no sender idling

    // 20 ns clock
    always #10 i_clk = ~i_clk;

    shared_buffer_multi_queue_unit #(
        .SLOTS (SLOTS),
        .QUEUES(QUEUES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    sbmq_queue_check #(
        .SLOTS (SLOTS),
        .QUEUES(QUEUES)
    ) u_queue_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_busy   (busy),
        .i_item   (item),
        .i_valid  (o_valid),
        .i_result (o_result),
        .o_errors (errors),
        .o_pending(pending)
    );

    // run limit, covers the clearing pass after reset as well
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[shared_buffer_multi_queue_unit] ERROR");
            $finish;
        end
    end

    // one command beat: random idle cycles first unless calm, then start
    // held high until the beat is taken; called and left at a falling edge,
    // so start gets at most one assignment per falling edge
    task automatic send_beat(input logic [1:0] cmd, input logic [1:0] qid,
                             input logic [31:0] word);
        t_in_item cmd_beat;
        cmd_beat.command  = cmd;
        cmd_beat.queue_id = qid;
        cmd_beat.data     = word;
        while (!calm && $urandom_range(99) < 31) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        item  <= cmd_beat;
        // busy is sampled before the edge updates it, same as the block sees it
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // short directed run: empty queues, extremes of the data word, the spare
    // code, last-entry dequeue, then fill the whole store and hit full
    task automatic directed_traffic();
        send_beat(CMD_QUERY, 2'd0, 32'h1234_5678);
        send_beat(CMD_DEQ,   2'd0, 32'h0);          // dequeue on empty queue
        send_beat(CMD_SPARE, 2'd1, 32'hffff_ffff);  // spare code on empty queue
        send_beat(CMD_ENQ,   2'd0, 32'h7fff_ffff);
        send_beat(CMD_ENQ,   2'd0, 32'h8000_0000);
        send_beat(CMD_ENQ,   2'd1, 32'hffff_ffff);
        send_beat(CMD_ENQ,   2'd3, 32'h0);
        send_beat(CMD_SPARE, 2'd0, 32'h0);
        send_beat(CMD_DEQ,   2'd0, 32'h0);          // head moves on
        send_beat(CMD_DEQ,   2'd0, 32'h0);          // last entry leaves
        send_beat(CMD_DEQ,   2'd0, 32'h0);          // empty again
        // two slots in use, fourteen more fill the store
        for (int i = 0; i < SLOTS - 2; i++)
            send_beat(CMD_ENQ, 2'(i % QUEUES),
                      ((i % 2) ? 32'haaaa_aaaa : 32'h5555_5555) ^ 32'(i));
        send_beat(CMD_ENQ,   2'd2, 32'hdead_beef);  // no free slot
        send_beat(CMD_QUERY, 2'd2, 32'h0);
        send_beat(CMD_DEQ,   2'd2, 32'h0);
        send_beat(CMD_ENQ,   2'd1, 32'h0bad_f00d);  // reuses the freed slot
    endtask

    // random run in blocks of 40 beats, each block leaning to enqueue,
    // balanced, or leaning to dequeue, so the store swings between full
    // and empty with random queue numbers and data
    task automatic random_traffic();
        int          enq_pct;
        int          pick;
        logic [1:0]  cmd;
        logic [31:0] word;
        enq_pct = 50;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(2))
                    0:       enq_pct = 85;
                    1:       enq_pct = 50;
                    default: enq_pct = 15;
                endcase
            end
            // long stretch with back-to-back beats
            calm = (n >= 150 && n < 250);
            pick = $urandom_range(99);
            if (pick < 8)
                cmd = CMD_QUERY;
            else if (pick < 11)
                cmd = CMD_SPARE;
            else
                cmd = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            case ($urandom_range(7))
                0:       word = 32'h7fff_ffff;
                1:       word = 32'h8000_0000;
                2:       word = 32'h0;
                3:       word = 32'hffff_ffff;
                default: word = $urandom;
            endcase
            send_beat(cmd, 2'($urandom_range(QUEUES - 1)), word);
        end
        calm = 1'b0;
    endtask

    initial begin
        // synchronous reset, released at a falling edge
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // the clearing pass keeps busy high, send_beat simply waits it out
        directed_traffic();
        random_traffic();
        start <= 1'b0;
        // wait for every predicted result, then for the drain cycles
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("[shared_buffer_multi_queue_unit] OK");
        end else begin
            $display("[shared_buffer_multi_queue_unit] ERROR");
        end
        $finish;
    end

endmodule
